/* rtl/kget_pkg.sv */
package kget_pkg;

  // Fixed field widths of the channels and registers
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned ORDER_W = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  // Parameter defaults
  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_J,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Control that travels beside one point through the test chain
  typedef struct packed {
    logic valid;
    logic is_ref;   // token carries the i/j pair, sets the diameter
    logic skip;     // token is point i or j itself
  } tok_t;

endpackage

/* rtl/kget_in_if.sv */
interface kget_in_if;
  import kget_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic        [IDX_W-1:0]   load_index;
  logic signed [FIELD_W-1:0] x_coord;
  logic signed [FIELD_W-1:0] y_coord;
  logic        [IDX_W-1:0]   first_index;
  logic        [IDX_W-1:0]   second_index;

  modport source (
    output valid, mode, load_index, x_coord, y_coord, first_index, second_index,
    input  ready
  );
  modport sink (
    input  valid, mode, load_index, x_coord, y_coord, first_index, second_index,
    output ready
  );
endinterface

/* rtl/kget_out_if.sv */
interface kget_out_if;
  import kget_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_edge;
  logic [COUNT_W-1:0] inside_count;
  logic               index_error;

  modport source (
    output valid, is_edge, inside_count, index_error,
    input  ready
  );
  modport sink (
    input  valid, is_edge, inside_count, index_error,
    output ready
  );
endinterface

/* rtl/k_gabriel_edge_test_unit.sv */
// k-order Gabriel edge tester. Load transactions (mode 0) write one point into
// the store and return all-zero results in the next cycle. Query transactions
// (mode 1) name points i and j; the unit counts the other points among slots
// 0 .. min(point_count, MAX_POINTS)-1 that lie strictly inside the disc on
// diameter ij, saturating at gabriel_order+1, and flags is_edge when the count
// is at most gabriel_order. Bad indices (equal, or not below the effective
// count) return index_error in the next cycle. A good query first reads the
// second end point, then streams the slots 0 .. limit-1, limit being
// min(point_count, MAX_POINTS), out of the store (one read port) through a
// two-cell squaring chain (x and y) into the counter, drains the chain and the
// counter, and loads the output register once it is free. One transaction is
// worked on at a time; a finished result sits in the output register and the
// next transaction is taken as it leaves. Store entries are not cleared at
// reset; query only slots that were loaded.
module k_gabriel_edge_test_unit #(
  parameter int unsigned MAX_POINTS = kget_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = kget_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kget_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [kget_pkg::CFG_DATA_W-1:0] cfg_data_i,
  kget_in_if.sink                         in_i,
  kget_out_if.source                      out_o
);
  import kget_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_POINTS);
  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned EXT_W = (COORD_BITS > FIELD_W) ? COORD_BITS : FIELD_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ORDER_W-1:0] order_q;
  logic [COUNT_W-1:0] pcount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q  <= '0;
      pcount_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORDER: order_q  <= cfg_data_i[ORDER_W-1:0];
        REG_COUNT: pcount_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective point count
  logic [COUNT_W-1:0] limit;
  assign limit = (32'(pcount_q) < MAX_POINTS) ? pcount_q : COUNT_W'(MAX_POINTS);

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic signed [EXT_W-1:0] x_ext, y_ext;
  logic signed [C-1:0]     x_in, y_in;
  logic                    in_fire, is_load, slot_ok, idx_err;

  assign x_ext   = EXT_W'(in_i.x_coord);
  assign y_ext   = EXT_W'(in_i.y_coord);
  assign x_in    = x_ext[C-1:0];
  assign y_in    = y_ext[C-1:0];
  assign in_fire = in_i.valid & in_i.ready;
  assign is_load = (in_i.mode == MODE_LOAD);
  assign slot_ok = 32'(in_i.load_index) < MAX_POINTS;
  assign idx_err = (in_i.first_index == in_i.second_index) ||
                   (COUNT_W'(in_i.first_index) >= limit) ||
                   (COUNT_W'(in_i.second_index) >= limit);

  // ---------------------------------------------------------------------------
  // Point store: {x, y} per slot, registered read
  // ---------------------------------------------------------------------------
  logic [AW-1:0]    raddr;
  logic [2*C-1:0]   rdata;
  logic signed [C-1:0] rd_x, rd_y;

  kget_store #(
    .MAX_POINTS (MAX_POINTS),
    .WIDTH      (2 * C)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_fire && is_load && slot_ok),
    .waddr_i (AW'(in_i.load_index)),
    .wdata_i ({x_in, y_in}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_x = rdata[2*C-1:C];
  assign rd_y = rdata[C-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [IDX_W-1:0]   fi_q, sj_q;
  logic [COUNT_W-1:0] limit_q, k_q, k_d;
  logic               ref_pend_q, ref_pend_d;   // point j read is in flight
  logic               pend_valid_q, pend_valid_d; // point k read is in flight
  logic               pend_skip_q, pend_skip_d;
  logic               out_free, out_load, clear, pipe_busy;
  logic               res_edge, res_err;
  logic [COUNT_W-1:0] res_count, count;

  assign out_free = !out_o.valid || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && !is_load && !idx_err) begin
          state_d = ST_RD_J;
        end
      end
      ST_RD_J: state_d = ST_SCAN;
      ST_SCAN: begin
        if (k_q == limit_q - COUNT_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pend_valid_q && !pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_i.ready   = 1'b0;
    raddr        = AW'(in_i.first_index);
    k_d          = k_q;
    ref_pend_d   = 1'b0;
    pend_valid_d = 1'b0;
    pend_skip_d  = 1'b0;
    clear        = 1'b0;
    out_load     = 1'b0;
    res_edge     = 1'b0;
    res_count    = '0;
    res_err      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = out_free;
        k_d        = '0;
        if (in_fire) begin
          if (is_load) begin
            out_load = 1'b1;
          end else if (idx_err) begin
            out_load = 1'b1;
            res_err  = 1'b1;
          end else begin
            clear = 1'b1;
          end
        end
      end
      ST_RD_J: begin
        raddr      = AW'(sj_q);
        ref_pend_d = 1'b1;
      end
      ST_SCAN: begin
        raddr        = AW'(k_q);
        pend_valid_d = 1'b1;
        pend_skip_d  = (k_q == COUNT_W'(fi_q)) || (k_q == COUNT_W'(sj_q));
        k_d          = k_q + COUNT_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          res_count = count;
          res_edge  = (count <= COUNT_W'(order_q));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      k_q          <= '0;
      ref_pend_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_skip_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      ref_pend_q   <= ref_pend_d;
      pend_valid_q <= pend_valid_d;
      pend_skip_q  <= pend_skip_d;
    end
  end

  // query operands, held for the whole scan
  always_ff @(posedge clk_i) begin
    if (in_fire && !is_load) begin
      fi_q    <= in_i.first_index;
      sj_q    <= in_i.second_index;
      limit_q <= limit;
    end
  end

  // ---------------------------------------------------------------------------
  // End points and disc center (times two)
  // ---------------------------------------------------------------------------
  logic signed [C-1:0] xi_q, yi_q;
  logic signed [C:0]   sx_q, sy_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD_J) begin
      xi_q <= rd_x;   // point i arrives while j is being read
      yi_q <= rd_y;
    end
    if (ref_pend_q) begin
      sx_q <= (C + 1)'(xi_q) + (C + 1)'(rd_x);
      sy_q <= (C + 1)'(yi_q) + (C + 1)'(rd_y);
    end
  end

  // ---------------------------------------------------------------------------
  // Test chain. The first transaction through it is (pi - pj), giving the
  // squared diameter; every following one is (pi + pj) - 2 pk.
  // ---------------------------------------------------------------------------
  tok_t                tok;
  logic signed [C:0]   ax, bx, ay, by;
  logic [2*C+2:0]      sqx, sqy;

  assign tok.valid  = ref_pend_q | pend_valid_q;
  assign tok.is_ref = ref_pend_q;
  assign tok.skip   = pend_skip_q;

  assign ax = ref_pend_q ? (C + 1)'(xi_q) : sx_q;
  assign ay = ref_pend_q ? (C + 1)'(yi_q) : sy_q;
  assign bx = ref_pend_q ? (C + 1)'(rd_x) : {rd_x, 1'b0};
  assign by = ref_pend_q ? (C + 1)'(rd_y) : {rd_y, 1'b0};

  kget_cell #(.COORD_BITS (C)) u_cell_x (
    .clk_i (clk_i),
    .a_i   (ax),
    .b_i   (bx),
    .sq_o  (sqx)
  );

  kget_cell #(.COORD_BITS (C)) u_cell_y (
    .clk_i (clk_i),
    .a_i   (ay),
    .b_i   (by),
    .sq_o  (sqy)
  );

  kget_count #(.COORD_BITS (C)) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (clear),
    .tok_i   (tok),
    .sqx_i   (sqx),
    .sqy_i   (sqy),
    .order_i (order_q),
    .count_o (count),
    .busy_o  (pipe_busy)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic               out_valid_q;
  logic               is_edge_q, index_error_q;
  logic [COUNT_W-1:0] inside_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      is_edge_q      <= res_edge;
      inside_count_q <= res_count;
      index_error_q  <= res_err;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.is_edge      = is_edge_q;
  assign out_o.inside_count = inside_count_q;
  assign out_o.index_error  = index_error_q;

endmodule

/* rtl/kget_store.sv */
module kget_store #(
  parameter int unsigned MAX_POINTS = kget_pkg::MAX_POINTS_DEF,
  parameter int unsigned WIDTH      = 2 * kget_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(MAX_POINTS)-1:0] waddr_i,
  input  logic [WIDTH-1:0]              wdata_i,
  input  logic [$clog2(MAX_POINTS)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/kget_cell.sv */
// One axis of the disc test: registered difference, then registered square.
module kget_cell #(
  parameter int unsigned COORD_BITS = kget_pkg::COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic signed [COORD_BITS:0] a_i,
  input  logic signed [COORD_BITS:0] b_i,
  output logic [2*COORD_BITS+2:0]    sq_o
);

  localparam int unsigned DIFF_W = COORD_BITS + 2;
  localparam int unsigned SQ_W   = 2 * COORD_BITS + 3;

  logic signed [DIFF_W-1:0]   diff_d, diff_q;
  logic signed [2*DIFF_W-1:0] prod;

  assign diff_d = DIFF_W'(a_i) - DIFF_W'(b_i);
  assign prod   = diff_q * diff_q;

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_o   <= prod[SQ_W-1:0];
  end

endmodule

/* rtl/kget_count.sv */
// Sums the two axis squares, keeps the diameter term and the inside count.
module kget_count #(
  parameter int unsigned COORD_BITS = kget_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             clear_i,
  input  kget_pkg::tok_t                   tok_i,
  input  logic [2*COORD_BITS+2:0]          sqx_i,
  input  logic [2*COORD_BITS+2:0]          sqy_i,
  input  logic [kget_pkg::ORDER_W-1:0]     order_i,
  output logic [kget_pkg::COUNT_W-1:0]     count_o,
  output logic                             busy_o
);
  import kget_pkg::*;

  localparam int unsigned SUM_W = 2 * COORD_BITS + 4;

  tok_t               tok1_q, tok2_q;
  logic [SUM_W-1:0]   sum, r2_q;
  logic [COUNT_W-1:0] count_q, count_d, sat;

  // tokens follow the two cell stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q <= '0;
      tok2_q <= '0;
    end else begin
      tok1_q <= tok_i;
      tok2_q <= tok1_q;
    end
  end

  assign sum = SUM_W'(sqx_i) + SUM_W'(sqy_i);
  assign sat = COUNT_W'(order_i) + COUNT_W'(1);

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (tok2_q.valid && !tok2_q.is_ref && !tok2_q.skip &&
                 (sum < r2_q) && (count_q != sat)) begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok2_q.valid && tok2_q.is_ref) begin
      r2_q <= sum;
    end
  end

  assign count_o = count_q;
  assign busy_o  = tok1_q.valid | tok2_q.valid;

endmodule

/* dv/k_gabriel_edge_test_unit_tb.sv */
module k_gabriel_edge_test_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kget_pkg::*;

  localparam int unsigned NUM_SLOTS   = MAX_POINTS_DEF;
  // A full-store query runs with no transaction on either channel; allow
  // several times its length before calling it a hang.
  localparam int unsigned QUIET_LIMIT = 8 * (NUM_SLOTS + 16);
  localparam int unsigned IDLE_PCT    = 32;
  localparam int unsigned PHASE_OPS   = 60;

  // One input transaction as the driver puts it on the bus
  typedef struct {
    logic                      mode;
    logic        [IDX_W-1:0]   load_index;
    logic signed [FIELD_W-1:0] x_coord;
    logic signed [FIELD_W-1:0] y_coord;
    logic        [IDX_W-1:0]   first_index;
    logic        [IDX_W-1:0]   second_index;
  } point_op_t;

  // One result transaction
  typedef struct {
    logic               is_edge;
    logic [COUNT_W-1:0] inside_count;
    logic               index_error;
  } edge_verdict_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  kget_in_if  in_if ();
  kget_out_if out_if ();

  k_gabriel_edge_test_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Shadow copy of the point store and the two registers
  logic signed [FIELD_W-1:0] shadow_x [NUM_SLOTS];
  logic signed [FIELD_W-1:0] shadow_y [NUM_SLOTS];
  bit                        slot_loaded [NUM_SLOTS];
  int unsigned               order_reg;
  int unsigned               count_reg;

  point_op_t     pending_ops[$];       // waiting for the driver
  edge_verdict_t expected_verdicts[$]; // predicted, waiting for the DUT
  point_op_t     next_op;
  point_op_t     seen_op;
  edge_verdict_t want;

  int          in_flight;      // pushed but not yet checked
  int          mismatch_count;
  bit          in_handed;      // input transaction completed at last rising edge
  bit          calm;           // no idling on either side while set
  int unsigned quiet_cycles;

  // Clock: 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
    mismatch_count++;
  endtask

  // Expected result of one accepted transaction; loads update the shadow store.
  function automatic edge_verdict_t predict_verdict(input point_op_t op);
    edge_verdict_t v;
    int unsigned   span, i, j, hits;
    longint        xi, yi, xj, yj, sx, sy, dx, dy, diam2, dist2;
    v = '{default: '0};
    span = (count_reg > NUM_SLOTS) ? NUM_SLOTS : count_reg;
    if (op.mode == MODE_LOAD) begin
      shadow_x[op.load_index] = op.x_coord;
      shadow_y[op.load_index] = op.y_coord;
      return v;
    end
    i = op.first_index;
    j = op.second_index;
    if (i == j || i >= span || j >= span) begin
      v.index_error = 1'b1;
      return v;
    end
    xi = shadow_x[i];
    yi = shadow_y[i];
    xj = shadow_x[j];
    yj = shadow_y[j];
    sx = xi + xj;
    sy = yi + yj;
    diam2 = (xi - xj) * (xi - xj) + (yi - yj) * (yi - yj);
    hits = 0;
    // Doubled coordinates keep the disc test exact: point strictly inside
    // when |2k - (i + j)|^2 < |i - j|^2. Counting stops at order + 1.
    for (int k = 0; k < span && hits < order_reg + 1; k++) begin
      if (k == i || k == j) continue;
      dx = sx - 2 * longint'(shadow_x[k]);
      dy = sy - 2 * longint'(shadow_y[k]);
      dist2 = dx * dx + dy * dy;
      if (dist2 < diam2) hits++;
    end
    v.is_edge      = (hits <= order_reg);
    v.inside_count = COUNT_W'(hits);
    return v;
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_coord(input bit narrow);
    int v;
    v = narrow ? int'($urandom_range(0, 510)) - 255 : int'($urandom_range(0, 65535)) - 32768;
    return v[FIELD_W-1:0];
  endfunction

  // Stimulus queue helpers; unused fields carry random noise
  task automatic push_load(input int unsigned slot, input logic signed [FIELD_W-1:0] x,
                           input logic signed [FIELD_W-1:0] y);
    point_op_t op;
    op.mode         = MODE_LOAD;
    op.load_index   = IDX_W'(slot);
    op.x_coord      = x;
    op.y_coord      = y;
    op.first_index  = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
    op.second_index = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
    pending_ops = {pending_ops, op};
    slot_loaded[slot] = 1'b1;
    in_flight++;
  endtask

  task automatic push_query(input int unsigned i, input int unsigned j);
    point_op_t op;
    op.mode         = MODE_QUERY;
    op.load_index   = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
    op.x_coord      = rand_coord(1'b0);
    op.y_coord      = rand_coord(1'b0);
    op.first_index  = IDX_W'(i);
    op.second_index = IDX_W'(j);
    pending_ops = {pending_ops, op};
    in_flight++;
  endtask

  // Mostly good queries over the active slots, plus reloads and bad pairs
  task automatic push_random_op(input int unsigned n, input bit narrow);
    int unsigned pick, i, j;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      i = $urandom_range(0, n - 1);
      j = (i + $urandom_range(1, n - 1)) % n;
      push_query(i, j);
    end else if (pick < 82) begin
      i = pick[0] ? $urandom_range(0, n - 1) : $urandom_range(0, NUM_SLOTS - 1);
      push_load(i, rand_coord(narrow), rand_coord(narrow));
    end else if (pick < 91) begin
      i = $urandom_range(0, NUM_SLOTS - 1);
      push_query(i, i);
    end else begin
      i = $urandom_range(n, NUM_SLOTS - 1);
      j = $urandom_range(0, NUM_SLOTS - 1);
      if (pick[0]) push_query(i, j);
      else push_query(j, i);
    end
  endtask

  // Slots below a new point_count must hold a point before it is set
  task automatic fill_slots(input int unsigned n, input bit narrow);
    for (int s = 0; s < n && s < NUM_SLOTS; s++) begin
      if (!slot_loaded[s]) push_load(s, rand_coord(narrow), rand_coord(narrow));
    end
  endtask

  task automatic wait_drained();
    while (in_flight != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Only called with the unit idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_ORDER) order_reg = value % (1 << ORDER_W);
    else count_reg = value % (1 << COUNT_W);
  endtask

  // Input driver: changes at the falling edge, holds a transaction until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_handed)) begin
      in_handed = 1'b0;
      if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_op = pending_ops.pop_front();
        in_if.valid        <= 1'b1;
        in_if.mode         <= next_op.mode;
        in_if.load_index   <= next_op.load_index;
        in_if.x_coord      <= next_op.x_coord;
        in_if.y_coord      <= next_op.y_coord;
        in_if.first_index  <= next_op.first_index;
        in_if.second_index <= next_op.second_index;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk_i) begin
    if (rst_ni) out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Monitor: checks the result channel, then records the input transaction.
  // A result can never belong to an input taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected result, index_error", out_if.index_error, 0);
        end else begin
          want = expected_verdicts.pop_front();
          in_flight--;
          if (out_if.is_edge !== want.is_edge)
            report_mismatch("is_edge", out_if.is_edge, want.is_edge);
          if (out_if.inside_count !== want.inside_count)
            report_mismatch("inside_count", out_if.inside_count, want.inside_count);
          if (out_if.index_error !== want.index_error)
            report_mismatch("index_error", out_if.index_error, want.index_error);
        end
      end
      if (in_if.valid && in_if.ready) begin
        seen_op.mode         = in_if.mode;
        seen_op.load_index   = in_if.load_index;
        seen_op.x_coord      = in_if.x_coord;
        seen_op.y_coord      = in_if.y_coord;
        seen_op.first_index  = in_if.first_index;
        seen_op.second_index = in_if.second_index;
        expected_verdicts = {expected_verdicts, predict_verdict(seen_op)};
        in_handed = 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned n, ord;
    bit          narrow;
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = REG_ORDER;
    cfg_data_i          = '0;
    in_if.valid         = 1'b0;
    in_if.mode          = MODE_LOAD;
    in_if.load_index    = '0;
    in_if.x_coord       = '0;
    in_if.y_coord       = '0;
    in_if.first_index   = '0;
    in_if.second_index  = '0;
    out_if.ready        = 1'b0;
    in_flight           = 0;
    mismatch_count      = 0;
    in_handed           = 1'b0;
    calm                = 1'b0;
    quiet_cycles        = 0;
    order_reg           = 0;
    count_reg           = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: point_count is 0 after reset, so any query is an index error
    push_query(0, 1);
    // Coordinate extremes, the origin and three points next to it
    push_load(0, -16'sd32768, -16'sd32768);
    push_load(1, 16'sd32767, 16'sd32767);
    push_load(2, 16'sd0, 16'sd0);
    push_load(3, -16'sd32768, 16'sd32767);
    push_load(4, 16'sd32767, -16'sd32768);
    push_load(5, 16'sd1, 16'sd0);
    push_load(6, 16'sd0, 16'sd1);
    push_load(7, -16'sd1, -16'sd1);
    push_load(NUM_SLOTS - 1, 16'sd12345, -16'sd12345);
    wait_drained();

    write_register(REG_COUNT, 8);
    write_register(REG_ORDER, 0);
    push_query(0, 1);              // widest disc, saturates at order 0
    push_query(1, 0);
    push_query(3, 4);
    push_query(5, 6);              // origin sits exactly on the circle: not inside
    push_query(4, 4);              // equal ends
    push_query(0, 8);              // end at point_count
    push_query(NUM_SLOTS - 1, 2);  // end far above point_count
    wait_drained();

    write_register(REG_ORDER, (1 << ORDER_W) - 1);
    push_query(0, 1);
    push_query(3, 4);
    push_query(2, 7);
    wait_drained();

    write_register(REG_ORDER, 2);
    push_query(0, 1);
    push_query(6, 5);
    wait_drained();

    // Random phases over small stores; each sets both registers while idle
    for (int ph = 0; ph < 8; ph++) begin
      calm   = (ph == 3);
      narrow = ph[0];
      n      = (ph == 0) ? 2 : $urandom_range(3, 64);
      case ($urandom_range(0, 4))
        0: ord = 0;
        1: ord = 1;
        2: ord = $urandom_range(2, 6);
        3: ord = (1 << ORDER_W) - 1;
        default: ord = $urandom_range(0, (1 << ORDER_W) - 1);
      endcase
      fill_slots(n, narrow);
      wait_drained();
      write_register(REG_COUNT, n);
      write_register(REG_ORDER, ord);
      for (int t = 0; t < PHASE_OPS; t++) begin
        // Sender holds off mid-phase until every result is back
        if (ph == 5 && t == PHASE_OPS / 2) wait_drained();
        push_random_op(n, narrow);
      end
      wait_drained();
    end
    calm = 1'b0;

    // Counts at and above the store depth; equal ends keep every slot unread
    write_register(REG_COUNT, NUM_SLOTS);
    push_query(NUM_SLOTS - 1, NUM_SLOTS - 1);
    push_query(0, 0);
    wait_drained();

    write_register(REG_COUNT, (1 << COUNT_W) - 1);
    push_query(NUM_SLOTS - 1, NUM_SLOTS - 1);
    wait_drained();

    // Let any stray result show up before the verdict
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/kget_pkg.sv
rtl/kget_in_if.sv
rtl/kget_out_if.sv
rtl/kget_store.sv
rtl/kget_cell.sv
rtl/kget_count.sv
rtl/k_gabriel_edge_test_unit.sv
dv/k_gabriel_edge_test_unit_tb.sv
